// File: design/unique_id_order_table_unit_macros.svh
// ----------------------------------------------------------------------------
// unique_id_order_table_unit assertion macros
// Concurrent checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNIQUE_ID_ORDER_TABLE_UNIT_MACROS_SVH
`define UNIQUE_ID_ORDER_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define UIDOT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UIDOT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/uidot_pkg.sv
// ----------------------------------------------------------------------------
// uidot_pkg
// Types and codes shared by the order table modules.
// ----------------------------------------------------------------------------
package uidot_pkg;

    localparam int ID_W     = 32;
    localparam int QTY_W    = 32;
    localparam int ENTRY_W  = ID_W + QTY_W;
    localparam int COUNT_W  = 7;
    localparam int VOLUME_W = 38;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ID_W-1:0]  order_id;
        logic [QTY_W-1:0] quantity;
    } uidot_req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [COUNT_W-1:0]  entry_count;
        logic [VOLUME_W-1:0] total_volume;
    } uidot_rsp_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_ADD,
        UPD_SUB,
        UPD_CLEAR
    } uidot_upd_op_t;

    typedef struct packed {
        logic             valid;
        uidot_upd_op_t    op;
        logic [1:0]       status;
        logic [QTY_W-1:0] qty;
    } uidot_upd_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_SHIFT
    } uidot_seq_state_t;

endpackage

// File: design/unique_id_order_table_unit.sv
// Insert and delete search the table one entry per cycle; a delete that hits then
// shifts the tail, one entry per cycle. Clear and unused codes skip the search;
// busy stays low for them, and the table is not read.
// The result strobe is high in the first cycle with busy low; the next request may
// start in that cycle. The receiver cannot stall.
// Reset empties the table (count and volume zero); entry memory is not cleared.
// ----------------------------------------------------------------------------
// unique_id_order_table_unit
// Ordered table of unique order ids with quantities, count and total volume.
// ----------------------------------------------------------------------------
`include "unique_id_order_table_unit_macros.svh"

module unique_id_order_table_unit #(
    parameter int TABLE_CAPACITY = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  uidot_pkg::uidot_req_t req,
    output logic                  done,
    output uidot_pkg::uidot_rsp_t rsp
);

    import uidot_pkg::*;

    localparam int CNT_W   = $clog2(TABLE_CAPACITY + 1);
    localparam int ADDR_W  = $clog2(TABLE_CAPACITY);
    localparam int CNT_X_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUM_W   = (QTY_W + CNT_W > VOLUME_W) ? QTY_W + CNT_W : VOLUME_W;
    localparam logic [CNT_X_W-1:0] CAP_X = CNT_X_W'(TABLE_CAPACITY);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               done_reg;
    uidot_rsp_t         rsp_reg, rsp_next;
    logic [CNT_X_W-1:0] count_x;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    uidot_upd_t         upd;

    uidot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    uidot_seq #(
        .TABLE_CAPACITY (TABLE_CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .count     (count_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .upd       (upd)
    );

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (upd.valid)
        begin
            case (upd.op)
                UPD_ADD:
                begin
                    count_next = count_reg + CNT_W'(1);
                    sum_next   = sum_reg + SUM_W'(upd.qty);
                end
                UPD_SUB:
                begin
                    count_next = count_reg - CNT_W'(1);
                    sum_next   = sum_reg - SUM_W'(upd.qty);
                end
                UPD_CLEAR:
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
                default:
                begin
                end
            endcase
        end
        count_x              = CNT_X_W'(count_next);
        rsp_next.status      = upd.status;
        rsp_next.entry_count = count_x[COUNT_W-1:0];
        rsp_next.total_volume = sum_next[VOLUME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            done_reg  <= upd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    `UIDOT_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(TABLE_CAPACITY), "count over capacity")
    `UIDOT_ASSERT_NOW(a_full_count, done && rsp.status == STAT_FULL, rsp.entry_count == CAP_X[COUNT_W-1:0], "full status without full table")
    `UIDOT_ASSERT_NOW(a_busy_done, $fell(busy), done, "busy dropped without a result")
    `UIDOT_ASSERT_NEXT(a_clear, start && !busy && req.req_type == REQ_CLEAR, done && rsp.entry_count == '0 && rsp.total_volume == '0, "clear left entries")

endmodule

// File: design/uidot_ram.sv
// ----------------------------------------------------------------------------
// uidot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uidot_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/uidot_seq.sv
// ----------------------------------------------------------------------------
// uidot_seq
// Sequencer: id search over the table, append, gap-closing shift, and clear.
// ----------------------------------------------------------------------------
module uidot_seq #(
    parameter int TABLE_CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  uidot_pkg::uidot_req_t               req,
    input  logic [$clog2(TABLE_CAPACITY+1)-1:0] count,
    output logic                                ram_we,
    output logic [$clog2(TABLE_CAPACITY)-1:0]   ram_waddr,
    output logic [uidot_pkg::ENTRY_W-1:0]       ram_wdata,
    output logic [$clog2(TABLE_CAPACITY)-1:0]   ram_raddr,
    input  logic [uidot_pkg::ENTRY_W-1:0]       ram_rdata,
    output uidot_pkg::uidot_upd_t               upd
);

    import uidot_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_CAPACITY + 1);
    localparam int ADDR_W = $clog2(TABLE_CAPACITY);

    uidot_seq_state_t  state_reg, state_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic              is_del_reg, is_del_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [QTY_W-1:0]  qty_reg, qty_next;

    logic              hit;
    logic              more;

    assign hit  = cmp_vld_reg && (ram_rdata[ENTRY_W-1:QTY_W] == id_reg);
    assign more = rd_idx_reg < count;
    assign busy = state_reg != SEQ_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        is_del_reg  <= is_del_next;
        id_reg      <= id_next;
        qty_reg     <= qty_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        is_del_next  = is_del_reg;
        id_next      = id_reg;
        qty_next     = qty_reg;
        ram_we       = 1'b0;
        ram_waddr    = count[ADDR_W-1:0];
        ram_wdata    = {id_reg, qty_reg};
        ram_raddr    = rd_idx_reg[ADDR_W-1:0];
        upd          = '0;
        upd.op       = UPD_NONE;
        upd.status   = STAT_DONE;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (start)
                begin
                    id_next     = req.order_id;
                    qty_next    = req.quantity;
                    is_del_next = req.req_type == REQ_DELETE;
                    rd_idx_next = '0;
                    case (req.req_type) inside
                        REQ_INSERT, REQ_DELETE:
                        begin
                            state_next = SEQ_SCAN;
                        end
                        REQ_CLEAR:
                        begin
                            upd.valid = 1'b1;
                            upd.op    = UPD_CLEAR;
                        end
                        default:
                        begin
                            upd.valid = 1'b1;
                        end
                    endcase
                end
            end

            SEQ_SCAN:
            begin
                if (hit)
                begin
                    if (is_del_reg)
                    begin
                        qty_next    = ram_rdata[QTY_W-1:0];
                        rd_idx_next = CNT_W'(cmp_idx_reg) + CNT_W'(1);
                        state_next  = SEQ_SHIFT;
                    end
                    else
                    begin
                        upd.valid  = 1'b1;
                        upd.status = STAT_MISS;
                        state_next = SEQ_IDLE;
                    end
                end
                else if (more)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                else if (!cmp_vld_reg)
                begin
                    upd.valid  = 1'b1;
                    state_next = SEQ_IDLE;
                    if (is_del_reg)
                    begin
                        upd.status = STAT_MISS;
                    end
                    else if (count >= CNT_W'(TABLE_CAPACITY))
                    begin
                        upd.status = STAT_FULL;
                    end
                    else
                    begin
                        ram_we  = 1'b1;
                        upd.op  = UPD_ADD;
                        upd.qty = qty_reg;
                    end
                end
            end

            SEQ_SHIFT:
            begin
                if (cmp_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cmp_idx_reg - ADDR_W'(1);
                    ram_wdata = ram_rdata;
                end
                if (more)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx_reg[ADDR_W-1:0];
                    rd_idx_next  = rd_idx_reg + CNT_W'(1);
                end
                else if (!cmp_vld_reg)
                begin
                    upd.valid  = 1'b1;
                    upd.op     = UPD_SUB;
                    upd.qty    = qty_reg;
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

endmodule
